// ===== src/bounded_stack_sorted_readout_macros.svh =====
// ----------------------------------------------------------------------------
// bounded_stack_sorted_readout_macros.svh
// Assertion helpers for the stack block. All use clk and rst of the including
// module.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_STACK_SORTED_READOUT_MACROS_SVH
`define BOUNDED_STACK_SORTED_READOUT_MACROS_SVH

// same-cycle implication
`define BSSR_AST_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSSR_AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bssr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssr_pkg
// Shared constants and types of the bounded stack with sorted readout.
// ----------------------------------------------------------------------------
package bssr_pkg;

  localparam int STACK_DEPTH = 15;
  localparam int DATA_W      = 8;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int AW          = $clog2(STACK_DEPTH);
  // sort key: value above slot index, so equal values stay distinct
  localparam int KEY_W       = DATA_W + AW;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_LIST = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POPD = 4'b0010,
    S_SCAN = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] data;
    logic              last;
  } res_t;

endpackage

// ===== src/bounded_stack_sorted_readout.sv =====
`timescale 1ns / 1ps
// Push goes from accept straight to the result state; pop first passes one RAM
// read (S_POPD). A list of n entries returns each word after one scan of n RAM
// reads; the single read port of the entry RAM sets this. Results sit in an
// output register, so a word is accepted while the previous result waits.
// Sync reset empties the stack.
// ----------------------------------------------------------------------------
// bounded_stack_sorted_readout
// Bounded LIFO stack of 8-bit codes with push, pop and ascending listing.
// ----------------------------------------------------------------------------
module bounded_stack_sorted_readout (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [1:0]                  operation,
  input  logic [bssr_pkg::DATA_W-1:0] value,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [1:0]                  status,
  output logic [bssr_pkg::DATA_W-1:0] data_out,
  output logic                        last
);

  logic                        res_valid;
  logic                        res_ready;
  bssr_pkg::res_t              res;
  logic                        ram_we;
  logic [bssr_pkg::AW-1:0]     ram_waddr;
  logic [bssr_pkg::DATA_W-1:0] ram_wdata;
  logic [bssr_pkg::AW-1:0]     ram_raddr;
  logic [bssr_pkg::DATA_W-1:0] ram_rdata;

  bssr_ram #(
    .WIDTH (bssr_pkg::DATA_W),
    .DEPTH (bssr_pkg::STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bssr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .value     (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      status   <= res.status;
      data_out <= res.data;
      last     <= res.last;
    end
  end

endmodule

// ===== src/bssr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssr_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bssr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bssr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssr_core
// Stack sequencer: push/pop against the entry RAM, and the sorted listing as
// repeated minimum scans over the RAM, one entry read per cycle.
// ----------------------------------------------------------------------------
`include "bounded_stack_sorted_readout_macros.svh"

module bssr_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [1:0]                   operation,
  input  logic [bssr_pkg::DATA_W-1:0]  value,
  output logic                         res_valid,
  input  logic                         res_ready,
  output bssr_pkg::res_t               res,
  output logic                         ram_we,
  output logic [bssr_pkg::AW-1:0]      ram_waddr,
  output logic [bssr_pkg::DATA_W-1:0]  ram_wdata,
  output logic [bssr_pkg::AW-1:0]      ram_raddr,
  input  logic [bssr_pkg::DATA_W-1:0]  ram_rdata
);

  localparam int CNT_W  = bssr_pkg::CNT_W;
  localparam int AW     = bssr_pkg::AW;
  localparam int KEY_W  = bssr_pkg::KEY_W;
  localparam int DATA_W = bssr_pkg::DATA_W;

  bssr_pkg::state_t state, state_next;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] scan_addr;
  logic [CNT_W-1:0] emitted;
  logic [AW-1:0]    rd_idx;
  logic             rd_pend;
  logic             is_list;
  logic [KEY_W-1:0] prev_key;
  logic [KEY_W-1:0] best_key;
  logic             have_prev;
  logic             have_best;

  logic             full;
  logic             empty;
  logic [CNT_W-1:0] cnt_m1;
  logic             issue;
  logic             scan_done;
  logic [KEY_W-1:0] cand_key;
  logic             cand_ok;
  logic             more;

  assign full      = (count == CNT_W'(bssr_pkg::STACK_DEPTH));
  assign empty     = (count == '0);
  assign cnt_m1    = count - CNT_W'(1);
  assign issue     = (scan_addr < count);
  assign scan_done = !issue && !rd_pend;
  assign cand_key  = {ram_rdata, rd_idx};
  // next in order: above the word already listed, below the best so far
  assign cand_ok   = rd_pend && (!have_prev || (cand_key > prev_key)) &&
                     (!have_best || (cand_key < best_key));
  assign more      = is_list && !res.last;

  assign req_stall = (state != bssr_pkg::S_IDLE);
  assign res_valid = (state == bssr_pkg::S_RESP);

  assign ram_we    = (state == bssr_pkg::S_IDLE) && req_valid &&
                     (operation == bssr_pkg::OP_PUSH) && !full;
  assign ram_waddr = count[AW-1:0];
  assign ram_wdata = value;
  // pop reads the top entry in the accept cycle; the scan walks upward.
  // A push write always lands before any read of that slot.
  assign ram_raddr = (state == bssr_pkg::S_IDLE) ? cnt_m1[AW-1:0] : scan_addr[AW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      bssr_pkg::S_IDLE: begin
        if (req_valid) begin
          unique case (operation)
            bssr_pkg::OP_PUSH: state_next = bssr_pkg::S_RESP;
            bssr_pkg::OP_POP:  state_next = empty ? bssr_pkg::S_RESP : bssr_pkg::S_POPD;
            bssr_pkg::OP_LIST: state_next = empty ? bssr_pkg::S_RESP : bssr_pkg::S_SCAN;
            default:           state_next = bssr_pkg::S_IDLE;
          endcase
        end
      end
      bssr_pkg::S_POPD: state_next = bssr_pkg::S_RESP;
      bssr_pkg::S_SCAN: begin
        if (scan_done) begin
          state_next = bssr_pkg::S_RESP;
        end
      end
      bssr_pkg::S_RESP: begin
        if (res_ready) begin
          state_next = more ? bssr_pkg::S_SCAN : bssr_pkg::S_IDLE;
        end
      end
      default: state_next = bssr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bssr_pkg::S_IDLE;
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        bssr_pkg::S_IDLE: begin
          if (req_valid) begin
            is_list   <= (operation == bssr_pkg::OP_LIST);
            res.last  <= 1'b1;
            res.data  <= '0;
            rd_pend   <= 1'b0;
            scan_addr <= '0;
            emitted   <= '0;
            have_prev <= 1'b0;
            have_best <= 1'b0;
            unique case (operation)
              bssr_pkg::OP_PUSH: begin
                if (full) begin
                  res.status <= bssr_pkg::ST_FULL;
                end else begin
                  res.status <= bssr_pkg::ST_OK;
                  count      <= count + CNT_W'(1);
                end
              end
              bssr_pkg::OP_POP: begin
                if (empty) begin
                  res.status <= bssr_pkg::ST_EMPTY;
                end else begin
                  res.status <= bssr_pkg::ST_OK;
                  count      <= cnt_m1;
                end
              end
              bssr_pkg::OP_LIST: begin
                if (empty) begin
                  res.status <= bssr_pkg::ST_EMPTY;
                end else begin
                  res.status <= bssr_pkg::ST_OK;
                end
              end
              default: res.status <= bssr_pkg::ST_OK;
            endcase
          end
        end
        bssr_pkg::S_POPD: begin
          res.data <= ram_rdata;
        end
        bssr_pkg::S_SCAN: begin
          if (issue) begin
            scan_addr <= scan_addr + CNT_W'(1);
          end
          rd_pend <= issue;
          rd_idx  <= scan_addr[AW-1:0];
          if (cand_ok) begin
            best_key  <= cand_key;
            have_best <= 1'b1;
          end
          if (scan_done) begin
            res.status <= bssr_pkg::ST_OK;
            res.data   <= best_key[KEY_W-1 -: DATA_W];
            res.last   <= ((emitted + CNT_W'(1)) == count);
          end
        end
        bssr_pkg::S_RESP: begin
          if (res_ready && more) begin
            prev_key  <= best_key;
            have_prev <= 1'b1;
            have_best <= 1'b0;
            emitted   <= emitted + CNT_W'(1);
            scan_addr <= '0;
            rd_pend   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  `BSSR_AST_IMPL(a_count_bound, 1'b1, count <= CNT_W'(bssr_pkg::STACK_DEPTH), "count over depth")
  `BSSR_AST_NEXT(a_push_inc, ram_we, count == $past(count) + CNT_W'(1), "push lost count")
  `BSSR_AST_IMPL(a_scan_range, state == bssr_pkg::S_SCAN, emitted < count, "listing overran")
  `BSSR_AST_NEXT(a_list_cont, res_valid && res_ready && more, state == bssr_pkg::S_SCAN, "listing cut short")

endmodule

// ===== test/tb_bounded_stack_sorted_readout.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_stack_sorted_readout
// Self-checking bench for the bounded stack with sorted readout. A queue of
// request words (directed corner cases, then random fill/drain/churn phases)
// feeds a bursty driver; a shadow stack predicts every reply, and a monitor
// behind a randomly stalling receiver checks each reply field by field.
// ----------------------------------------------------------------------------
module tb_bounded_stack_sorted_readout;

  localparam logic [1:0] OP_UNUSED   = 2'd3;  // reserved code, block ignores it
  localparam int         RAND_WORDS  = 440;
  localparam int         DRAIN_WAIT  = 400;   // > full-stack list time
  localparam int         CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [1:0]                  op;
    logic [bssr_pkg::DATA_W-1:0] val;
    bit                          hold;  // wait for all replies before sending
  } req_word_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        req_valid = 1'b0;
  logic                        req_stall;
  logic [1:0]                  operation = bssr_pkg::OP_PUSH;
  logic [bssr_pkg::DATA_W-1:0] value = '0;
  logic                        rsp_valid;
  logic                        rsp_stall = 1'b0;
  logic [1:0]                  status;
  logic [bssr_pkg::DATA_W-1:0] data_out;
  logic                        last;

  req_word_t                   req_words[$];
  bssr_pkg::res_t              replies_due[$];
  logic [bssr_pkg::DATA_W-1:0] shadow_stack[$];

  int errors = 0;
  int cycle_cnt = 0;
  int n_push = 0, n_pop = 0, n_list = 0, n_full = 0, n_empty = 0, n_ignored = 0;
  int n_checked = 0, deepest_list = 0;

  // sender pacing
  int burst_left = 8;
  int gap_left = 0;
  // receiver pacing
  int calm_left = 0;
  int stall_run = 0;

  bounded_stack_sorted_readout DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .value     (value),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .data_out  (data_out),
    .last      (last)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("MISMATCH @%0t %s: expected %0d, got %0d", $realtime, what, want, got);
    errors++;
  endtask

  function automatic bssr_pkg::res_t make_reply(bssr_pkg::status_t st,
                                                logic [bssr_pkg::DATA_W-1:0] d,
                                                logic lst);
    bssr_pkg::res_t r;
    r.status = st;
    r.data   = d;
    r.last   = lst;
    return r;
  endfunction

  // apply one accepted word to the shadow stack and queue the replies it owes
  task automatic stack_apply(input logic [1:0] op,
                             input logic [bssr_pkg::DATA_W-1:0] val);
    logic [bssr_pkg::DATA_W-1:0] sorted[$];
    case (op)
      bssr_pkg::OP_PUSH: begin
        if (shadow_stack.size() >= bssr_pkg::STACK_DEPTH) begin
          replies_due.push_back(make_reply(bssr_pkg::ST_FULL, '0, 1'b1));
          n_full++;
        end else begin
          shadow_stack.push_back(val);
          replies_due.push_back(make_reply(bssr_pkg::ST_OK, '0, 1'b1));
        end
        n_push++;
      end
      bssr_pkg::OP_POP: begin
        if (shadow_stack.size() == 0) begin
          replies_due.push_back(make_reply(bssr_pkg::ST_EMPTY, '0, 1'b1));
          n_empty++;
        end else begin
          replies_due.push_back(make_reply(bssr_pkg::ST_OK, shadow_stack.pop_back(), 1'b1));
        end
        n_pop++;
      end
      bssr_pkg::OP_LIST: begin
        if (shadow_stack.size() == 0) begin
          replies_due.push_back(make_reply(bssr_pkg::ST_EMPTY, '0, 1'b1));
          n_empty++;
        end else begin
          sorted = shadow_stack;
          sorted.sort();
          foreach (sorted[i])
            replies_due.push_back(make_reply(bssr_pkg::ST_OK, sorted[i],
                                             i == sorted.size() - 1));
          if (sorted.size() > deepest_list) deepest_list = sorted.size();
        end
        n_list++;
      end
      default: n_ignored++;
    endcase
  endtask

  // driver: bursts of words with random gaps
  always @(posedge clk) begin
    logic      next_valid;
    req_word_t w;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      next_valid = req_valid;
      if (req_valid && !req_stall) begin
        stack_apply(operation, value);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_words.size() != 0 &&
                     !(req_words[0].hold && replies_due.size() != 0)) begin
          w = req_words.pop_front();
          operation  <= w.op;
          value      <= w.val;
          next_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      req_valid <= next_valid;
    end
  end

  // monitor: receiver stalls in runs, checks each accepted reply
  always @(posedge clk) begin
    bssr_pkg::res_t exp_r;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected reply, status", -1, int'(status));
        end else begin
          exp_r = replies_due.pop_front();
          if (status !== exp_r.status)
            report_mismatch("status", int'(exp_r.status), int'(status));
          if (data_out !== exp_r.data)
            report_mismatch("data_out", int'(exp_r.data), int'(data_out));
          if (last !== exp_r.last)
            report_mismatch("last", int'(exp_r.last), int'(last));
          n_checked++;
        end
      end
      if (calm_left > 0) begin
        calm_left--;
        rsp_stall <= 1'b0;
      end else if (stall_run > 0) begin
        stall_run--;
        rsp_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 9) < 4) calm_left = $urandom_range(5, 60);
        else stall_run = $urandom_range(1, 6);
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic queue_word(input logic [1:0] op, input logic [bssr_pkg::DATA_W-1:0] val,
                            input bit hold);
    req_word_t w;
    w.op   = op;
    w.val  = val;
    w.hold = hold;
    req_words.push_back(w);
  endtask

  // timeout
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [bssr_pkg::DATA_W-1:0] fill_vals[15];
    int depth, mode, mode_left, sent, pick;
    logic [1:0] op;

    fill_vals = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd127, 8'd7, 8'd7, 8'd200,
                  8'd0, 8'd64, 8'd255, 8'd3, 8'd99, 8'd170, 8'd85};

    // directed: empty cases, fill to full with duplicates, overflow, lists
    queue_word(OP_UNUSED, 8'hA5, 1'b0);
    queue_word(bssr_pkg::OP_LIST, 8'h00, 1'b0);
    queue_word(bssr_pkg::OP_POP, 8'hFF, 1'b0);
    foreach (fill_vals[i]) queue_word(bssr_pkg::OP_PUSH, fill_vals[i], 1'b0);
    queue_word(bssr_pkg::OP_PUSH, 8'h5A, 1'b0);
    queue_word(bssr_pkg::OP_LIST, 8'hFF, 1'b0);
    queue_word(OP_UNUSED, 8'h5A, 1'b0);
    queue_word(bssr_pkg::OP_POP, 8'h00, 1'b0);
    queue_word(bssr_pkg::OP_LIST, 8'h00, 1'b1);
    depth = bssr_pkg::STACK_DEPTH - 1;

    // random: fill, drain and churn phases so both full and empty recur
    sent = 0;
    mode = 0;
    mode_left = 0;
    while (sent < RAND_WORDS) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(6, 30);
      end
      if ($urandom_range(0, 24) == 0) begin
        queue_word(OP_UNUSED, 8'($urandom_range(0, 255)), 1'b0);
      end else begin
        pick = $urandom_range(0, 99);
        case (mode)
          0:       op = (pick < 70) ? bssr_pkg::OP_PUSH :
                        (pick < 85) ? bssr_pkg::OP_POP : bssr_pkg::OP_LIST;
          1:       op = (pick < 15) ? bssr_pkg::OP_PUSH :
                        (pick < 85) ? bssr_pkg::OP_POP : bssr_pkg::OP_LIST;
          default: op = (pick < 40) ? bssr_pkg::OP_PUSH :
                        (pick < 80) ? bssr_pkg::OP_POP : bssr_pkg::OP_LIST;
        endcase
        queue_word(op, 8'($urandom_range(0, 255)),
                   sent == 0 || $urandom_range(0, 49) == 0);
        if (op == bssr_pkg::OP_PUSH && depth < bssr_pkg::STACK_DEPTH) depth++;
        if (op == bssr_pkg::OP_POP && depth > 0) depth--;
        sent++;
        mode_left--;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (req_words.size() != 0 || req_valid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (replies_due.size() != 0)
      report_mismatch("replies never seen", 0, replies_due.size());

    $display("run: %0d push, %0d pop, %0d list, %0d ignored words; %0d replies checked",
             n_push, n_pop, n_list, n_ignored, n_checked);
    $display("run: %0d full and %0d empty refusals, longest listing %0d entries, %0d errors",
             n_full, n_empty, deepest_list, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
